// ===== hdl/ptob_pkg.sv =====
// ---------------------------------------------------------------------------
// Price-time order book package
// Shared widths, codes and the slot and cell command structures.
// ---------------------------------------------------------------------------
`default_nettype none
package ptob_pkg;
  localparam int ORDER_SLOTS  = 32;
  localparam int LEVEL_COUNT  = 1024;
  localparam int SLOT_W  = $clog2(ORDER_SLOTS);
  localparam int LEVEL_W = $clog2(LEVEL_COUNT);
  localparam int ID_W    = 63;
  localparam int PRICE_W = 10;
  localparam int QTY_W   = 31;
  localparam int TOT_W   = 36;
  localparam int CNT_W   = 32;
  localparam logic [PRICE_W-1:0] PRICE_MAX = PRICE_W'(LEVEL_COUNT - 1);

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_CANCEL = 3'd1;
  localparam logic [2:0] OP_REDUCE = 3'd2;
  localparam logic [2:0] OP_QUERY  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [3:0] ST_RESTED    = 4'd0;
  localparam logic [3:0] ST_FILLED    = 4'd1;
  localparam logic [3:0] ST_CANCELLED = 4'd2;
  localparam logic [3:0] ST_REDUCED   = 4'd3;
  localparam logic [3:0] ST_UNKNOWN   = 4'd4;
  localparam logic [3:0] ST_FULL      = 4'd5;
  localparam logic [3:0] ST_DUP       = 4'd6;
  localparam logic [3:0] ST_SIDE      = 4'd7;
  localparam logic [3:0] ST_CLEARED   = 4'd8;

  // Contents of one order slot.
  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   rem;
    logic [CNT_W-1:0]   arrival;
  } slot_t;

  // Command from the sequencer to every cell.
  typedef struct packed {
    logic               write;
    logic               clear;
    logic [SLOT_W-1:0]  sel;
    slot_t              data;
  } cell_cmd_t;
endpackage
`default_nettype wire

// ===== hdl/ptob_cell.sv =====
// ---------------------------------------------------------------------------
// Order slot cell
// Holds one order slot and passes it on the scan chain when shifting is enabled.
// ---------------------------------------------------------------------------
`default_nettype none
module ptob_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [ptob_pkg::SLOT_W-1:0] my_idx,
  input  wire ptob_pkg::cell_cmd_t cmd,
  input  wire logic               shift_en,
  input  wire ptob_pkg::slot_t    scan_in,
  output ptob_pkg::slot_t         scan_out
);
  import ptob_pkg::*;
  slot_t slot_r, slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (shift_en) begin
      slot_nxt = scan_in;
    end else if (cmd.sel == my_idx) begin
      if (cmd.write) slot_nxt = cmd.data;
      else if (cmd.clear) slot_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) slot_r.valid <= 1'b0;
    else slot_r.valid <= slot_nxt.valid;
    slot_r.id      <= slot_nxt.id;
    slot_r.side    <= slot_nxt.side;
    slot_r.price   <= slot_nxt.price;
    slot_r.rem     <= slot_nxt.rem;
    slot_r.arrival <= slot_nxt.arrival;
  end

  assign scan_out = slot_r;
endmodule
`default_nettype wire

// ===== hdl/price_time_order_book_matcher.sv =====
// ---------------------------------------------------------------------------
// Price-time order book matcher
// Clear and unknown operations go straight to the summary scan; cancel, reduce
// and query first scan for the id; an add also scans for a match before each trade.
// A stalled result holds the block in its trade or summary output state.
// One transaction at a time; the next is accepted after the summary is taken.
// Reset clears slots and counters, then sweeps every level memory entry to zero.
// ---------------------------------------------------------------------------
`default_nettype none
module price_time_order_book_matcher (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  in_operation,
  input  wire logic [62:0]                 in_order_id,
  input  wire logic [9:0]                  in_price_index,
  input  wire logic [30:0]                 in_quantity,
  input  wire logic                        in_side,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_kind,
  output logic                             out_last,
  output logic [62:0]                      out_resting_id,
  output logic [9:0]                       out_trade_price,
  output logic [30:0]                      out_trade_quantity,
  output logic [3:0]                       out_status,
  output logic                             out_queried_side,
  output logic [9:0]                       out_best_bid_index,
  output logic [35:0]                      out_best_bid_total,
  output logic [9:0]                       out_best_ask_index,
  output logic [35:0]                      out_best_ask_total,
  output logic [31:0]                      out_trade_count
);
  import ptob_pkg::*;

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_LOOK  = 9'b000000100,
    S_MATCH = 9'b000001000,
    S_TRADE = 9'b000010000,
    S_REST  = 9'b000100000,
    S_MOD   = 9'b001000000,
    S_SUMM  = 9'b010000000,
    S_SOUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Cell ring.
  slot_t     chain [ORDER_SLOTS];
  cell_cmd_t cmd;
  logic      shift_en;
  genvar g;
  generate
    for (g = 0; g < ORDER_SLOTS; g++) begin : g_cell
      ptob_cell u_cell (
        .clk(clk), .rst_n(rst_n), .my_idx(SLOT_W'(g)), .cmd(cmd),
        .shift_en(shift_en),
        .scan_in(chain[(g + 1) % ORDER_SLOTS]),
        .scan_out(chain[g])
      );
    end
  endgenerate
  slot_t head;
  assign head = chain[0];

  // Level memory.
  logic [TOT_W-1:0] level_mem [LEVEL_COUNT];
  logic             lm_we;
  logic [LEVEL_W-1:0] lm_waddr, lm_raddr;
  logic [TOT_W-1:0] lm_wdata, lm_rdata_r;
  always_ff @(posedge clk) begin
    if (lm_we) level_mem[lm_waddr] <= lm_wdata;
    lm_rdata_r <= level_mem[lm_raddr];
  end

  // Item registers.
  logic [2:0]         op_r;
  logic [ID_W-1:0]    id_r;
  logic [PRICE_W-1:0] price_r;
  logic [QTY_W-1:0]   qty_r, qty_nxt;
  logic               sd_r;
  logic [CNT_W-1:0]   arr_cnt_r, arr_cnt_nxt, trd_cnt_r, trd_cnt_nxt;
  logic [CNT_W-1:0]   my_arr_r, my_arr_nxt;

  // Scan results; the rotation tracks the physical slot at the head.
  logic [SLOT_W:0]    pos_r, pos_nxt;
  logic [SLOT_W-1:0]  rot_r, rot_nxt;
  logic               found_r, found_nxt, free_r, free_nxt;
  logic [SLOT_W-1:0]  hit_r, hit_nxt, free_idx_r, free_idx_nxt;
  slot_t              hit_slot_r, hit_slot_nxt;
  logic               bb_f_r, bb_f_nxt, ba_f_r, ba_f_nxt;
  logic [PRICE_W-1:0] bb_r, bb_nxt, ba_r, ba_nxt;
  logic [TOT_W-1:0]   bbt_r, bbt_nxt;
  logic [5:0]         ntr_r, ntr_nxt;
  logic [3:0]         status_r, status_nxt;
  logic               qside_r, qside_nxt;
  logic [LEVEL_W:0]   init_r, init_nxt;
  logic [1:0]         sub_r, sub_nxt;

  // Output register.
  logic               ov_r, ov_nxt, okind_r, okind_nxt;
  logic [ID_W-1:0]    oid_r, oid_nxt;
  logic [PRICE_W-1:0] oprice_r, oprice_nxt;
  logic [QTY_W-1:0]   oqty_r, oqty_nxt;

  logic [SLOT_W-1:0]  head_idx;
  assign head_idx = rot_r;
  logic scan_end;
  assign scan_end = (pos_r == (SLOT_W+1)'(ORDER_SLOTS));

  logic cand, better;
  logic [CNT_W-1:0] age_h, age_b;
  logic [QTY_W-1:0] take;
  logic [TOT_W-1:0] qty_ext;
  assign qty_ext = TOT_W'(qty_r);
  assign age_h = arr_cnt_r - head.arrival;
  assign age_b = arr_cnt_r - hit_slot_r.arrival;
  always_comb begin
    cand = head.valid && (head.side != sd_r) &&
           (sd_r ? (head.price >= price_r) : (head.price <= price_r));
    if (!found_r) better = 1'b1;
    else if (head.price == hit_slot_r.price) better = age_h > age_b;
    else better = sd_r ? (head.price > hit_slot_r.price)
                       : (head.price < hit_slot_r.price);
  end
  assign take = (qty_r < hit_slot_r.rem) ? qty_r : hit_slot_r.rem;

  logic [PRICE_W-1:0] in_price_sat;
  assign in_price_sat = (32'(in_price_index) >= LEVEL_COUNT) ? PRICE_MAX : in_price_index;

  assign in_stall = (state_r != S_IDLE) || ov_r;
  logic accept;
  assign accept = in_valid && !in_stall;
  logic out_free;
  assign out_free = !ov_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    shift_en = 1'b0;
    lm_we = 1'b0; lm_waddr = '0; lm_wdata = '0; lm_raddr = '0;
    qty_nxt = qty_r; arr_cnt_nxt = arr_cnt_r; trd_cnt_nxt = trd_cnt_r;
    my_arr_nxt = my_arr_r;
    pos_nxt = pos_r; rot_nxt = rot_r;
    found_nxt = found_r; free_nxt = free_r; hit_nxt = hit_r;
    free_idx_nxt = free_idx_r; hit_slot_nxt = hit_slot_r;
    bb_f_nxt = bb_f_r; ba_f_nxt = ba_f_r; bb_nxt = bb_r; ba_nxt = ba_r;
    bbt_nxt = bbt_r; ntr_nxt = ntr_r; status_nxt = status_r;
    qside_nxt = qside_r; init_nxt = init_r; sub_nxt = sub_r;
    ov_nxt = ov_r && out_stall; okind_nxt = okind_r;
    oid_nxt = oid_r; oprice_nxt = oprice_r; oqty_nxt = oqty_r;
    unique case (state_r)
      S_INIT: begin
        lm_we = 1'b1; lm_waddr = init_r[LEVEL_W-1:0];
        init_nxt = init_r + 1'b1;
        if (init_r == (LEVEL_W+1)'(LEVEL_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          qty_nxt = in_quantity; pos_nxt = '0; found_nxt = 1'b0;
          free_nxt = 1'b0; ntr_nxt = '0; qside_nxt = 1'b0;
          status_nxt = ST_UNKNOWN;
          state_nxt = (in_operation == OP_CLEAR || in_operation > OP_CLEAR)
                      ? S_SUMM : S_LOOK;
          if (in_operation == OP_CLEAR) begin
            trd_cnt_nxt = '0; status_nxt = ST_CLEARED;
          end
          bb_f_nxt = 1'b0; ba_f_nxt = 1'b0;
        end
      end
      S_LOOK: begin
        // Find the id and the first free slot.
        if (!scan_end) begin
          shift_en = 1'b1; rot_nxt = rot_r + 1'b1; pos_nxt = pos_r + 1'b1;
          if (head.valid && head.id == id_r && !found_r) begin
            found_nxt = 1'b1; hit_nxt = head_idx; hit_slot_nxt = head;
          end
          if (!head.valid && !free_r) begin
            free_nxt = 1'b1; free_idx_nxt = head_idx;
          end
        end else begin
          pos_nxt = '0;
          lm_raddr = hit_slot_r.price[LEVEL_W-1:0];
          if (op_r == OP_ADD) begin
            if (found_r) begin
              status_nxt = ST_DUP; state_nxt = S_SUMM;
            end else if (!free_r) begin
              status_nxt = ST_FULL; state_nxt = S_SUMM;
            end else begin
              my_arr_nxt = arr_cnt_r; arr_cnt_nxt = arr_cnt_r + 1'b1;
              found_nxt = 1'b0; state_nxt = S_MATCH;
            end
          end else if (!found_r) begin
            state_nxt = S_SUMM;
          end else begin
            sub_nxt = '0; state_nxt = S_MOD;
          end
        end
      end
      S_MATCH: begin
        if (qty_r == '0 || ntr_r == 6'(ORDER_SLOTS)) begin
          sub_nxt = '0; state_nxt = S_REST;
        end else if (!scan_end) begin
          shift_en = 1'b1; rot_nxt = rot_r + 1'b1; pos_nxt = pos_r + 1'b1;
          if (cand && better) begin
            found_nxt = 1'b1; hit_nxt = head_idx; hit_slot_nxt = head;
          end
        end else begin
          pos_nxt = '0;
          if (!found_r) begin
            sub_nxt = '0; state_nxt = S_REST;
          end else begin
            lm_raddr = hit_slot_r.price[LEVEL_W-1:0];
            sub_nxt = '0; state_nxt = S_TRADE;
          end
        end
      end
      S_TRADE: begin
        lm_raddr = hit_slot_r.price[LEVEL_W-1:0];
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else if (out_free) begin
          lm_we = 1'b1; lm_waddr = hit_slot_r.price[LEVEL_W-1:0];
          lm_wdata = lm_rdata_r - TOT_W'(take);
          cmd.sel = hit_r;
          cmd.write = 1'b1;
          cmd.data = hit_slot_r;
          cmd.data.rem = hit_slot_r.rem - take;
          if (hit_slot_r.rem == take) cmd.data.valid = 1'b0;
          qty_nxt = qty_r - take;
          trd_cnt_nxt = trd_cnt_r + 1'b1;
          ntr_nxt = ntr_r + 1'b1;
          ov_nxt = 1'b1; okind_nxt = 1'b0; oid_nxt = hit_slot_r.id;
          oprice_nxt = hit_slot_r.price; oqty_nxt = take;
          found_nxt = 1'b0; state_nxt = S_MATCH;
        end
      end
      S_REST: begin
        // Rest the remainder, if any, in the first free slot found earlier; trades only
        // free slots, so that slot is still free and the lowest free one may
        // differ, which only matters for undefined contents.
        if (qty_r == '0) begin
          status_nxt = ST_FILLED; state_nxt = S_SUMM;
        end else if (sub_r == 2'd0 || sub_r == 2'd1) begin
          lm_raddr = price_r[LEVEL_W-1:0];
          sub_nxt = (sub_r == 2'd0) ? 2'd2 : 2'd2;
        end else begin
          lm_we = 1'b1; lm_waddr = price_r[LEVEL_W-1:0];
          lm_wdata = lm_rdata_r + qty_ext;
          cmd.sel = free_idx_r; cmd.write = 1'b1;
          cmd.data.valid = 1'b1; cmd.data.id = id_r; cmd.data.side = sd_r;
          cmd.data.price = price_r; cmd.data.rem = qty_r;
          cmd.data.arrival = my_arr_r;
          status_nxt = ST_RESTED; state_nxt = S_SUMM;
        end
      end
      S_MOD: begin
        lm_raddr = hit_slot_r.price[LEVEL_W-1:0];
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          lm_waddr = hit_slot_r.price[LEVEL_W-1:0];
          cmd.sel = hit_r;
          if (op_r == OP_QUERY) begin
            status_nxt = ST_SIDE; qside_nxt = hit_slot_r.side;
          end else if (op_r == OP_CANCEL || qty_r >= hit_slot_r.rem) begin
            lm_we = 1'b1; lm_wdata = lm_rdata_r - TOT_W'(hit_slot_r.rem);
            cmd.clear = 1'b1; status_nxt = ST_CANCELLED;
          end else begin
            lm_we = 1'b1; lm_wdata = lm_rdata_r - qty_ext;
            cmd.write = 1'b1; cmd.data = hit_slot_r;
            cmd.data.rem = hit_slot_r.rem - qty_r;
            status_nxt = ST_REDUCED;
          end
          state_nxt = S_SUMM;
        end
      end
      S_SUMM: begin
        // Scan for best bid and ask, then read both level totals.
        if (!scan_end) begin
          shift_en = 1'b1; rot_nxt = rot_r + 1'b1; pos_nxt = pos_r + 1'b1;
          if (head.valid && !head.side && (!bb_f_r || head.price > bb_r)) begin
            bb_f_nxt = 1'b1; bb_nxt = head.price;
          end
          if (head.valid && head.side && (!ba_f_r || head.price < ba_r)) begin
            ba_f_nxt = 1'b1; ba_nxt = head.price;
          end
          sub_nxt = '0;
        end else begin
          sub_nxt = sub_r + 1'b1;
          lm_raddr = (sub_r == 2'd0) ? bb_r[LEVEL_W-1:0] : ba_r[LEVEL_W-1:0];
          if (sub_r == 2'd1) bbt_nxt = lm_rdata_r;
          if (sub_r == 2'd2) state_nxt = S_SOUT;
        end
      end
      S_SOUT: begin
        if (out_free) begin
          ov_nxt = 1'b1; okind_nxt = 1'b1;
          pos_nxt = '0; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  logic [TOT_W-1:0] bat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; init_r <= '0; ov_r <= 1'b0;
      arr_cnt_r <= '0; trd_cnt_r <= '0; rot_r <= '0; pos_r <= '0;
      sub_r <= '0;
    end else begin
      state_r <= state_nxt; init_r <= init_nxt; ov_r <= ov_nxt;
      arr_cnt_r <= arr_cnt_nxt; trd_cnt_r <= trd_cnt_nxt; rot_r <= rot_nxt;
      pos_r <= pos_nxt; sub_r <= sub_nxt;
    end
    if (accept) begin
      op_r <= in_operation; id_r <= in_order_id; price_r <= in_price_sat;
      sd_r <= in_side;
    end
    if (state_r == S_SUMM && scan_end && sub_r == 2'd2) bat_r <= lm_rdata_r;
    qty_r <= qty_nxt; my_arr_r <= my_arr_nxt;
    found_r <= found_nxt; free_r <= free_nxt; hit_r <= hit_nxt;
    free_idx_r <= free_idx_nxt; hit_slot_r <= hit_slot_nxt;
    bb_f_r <= bb_f_nxt; ba_f_r <= ba_f_nxt; bb_r <= bb_nxt; ba_r <= ba_nxt;
    bbt_r <= bbt_nxt; ntr_r <= ntr_nxt; status_r <= status_nxt;
    qside_r <= qside_nxt; okind_r <= okind_nxt; oid_r <= oid_nxt;
    oprice_r <= oprice_nxt; oqty_r <= oqty_nxt;
  end

  assign out_valid          = ov_r;
  assign out_kind           = okind_r;
  assign out_last           = okind_r;
  assign out_resting_id     = okind_r ? '0 : oid_r;
  assign out_trade_price    = okind_r ? '0 : oprice_r;
  assign out_trade_quantity = okind_r ? '0 : oqty_r;
  assign out_status         = okind_r ? status_r : ST_RESTED;
  assign out_queried_side   = okind_r & qside_r;
  assign out_best_bid_index = (okind_r && bb_f_r) ? bb_r : '0;
  assign out_best_bid_total = (okind_r && bb_f_r) ? bbt_r : '0;
  assign out_best_ask_index = (okind_r && ba_f_r) ? ba_r : '0;
  assign out_best_ask_total = (okind_r && ba_f_r) ? bat_r : '0;
  assign out_trade_count    = okind_r ? trd_cnt_r : '0;
endmodule
`default_nettype wire

// ===== hdl/ptob_checker.sv =====
// ---------------------------------------------------------------------------
// Order book port checker
// Checks port behavior of the matcher over time.
// ---------------------------------------------------------------------------
`default_nettype none
module ptob_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_kind,
  input wire logic out_last,
  input wire logic [3:0] out_status
);
  import ptob_pkg::*;
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_kind)) else $error("last differs from kind");
  a_trade_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_kind) |-> (out_status == ST_RESTED))
    else $error("trade with status");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("accepted twice");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_kind)))
    else $error("stalled result changed");
endmodule

bind price_time_order_book_matcher ptob_checker u_ptob_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
  .out_last(out_last), .out_status(out_status)
);
`default_nettype wire
